// ===== design/ucps_pkg.sv =====
`default_nettype none

package ucps_pkg;

  // Character index counter width and the width shown on the output
  localparam int INDEX_WIDTH = 16;
  localparam int INDEX_OUT_W = 16;

  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 3;
  localparam int MAX_LEN = 4;

  typedef logic [MAX_LEN-1:0][BYTE_W-1:0] char_buf_t;

  // One request handed from the front to the back
  typedef struct packed {
    char_buf_t        bytes;   // collected bytes, first in [0]
    logic [LEN_W-1:0] count;   // number of valid bytes, 1..4
    logic             reseg;   // string ended inside a sequence
    logic             eos;     // request carries the final byte
  } job_t;

  // Sequence length announced by a lead byte
  function automatic logic [LEN_W-1:0] lead_length(input logic [BYTE_W-1:0] b);
    logic [LEN_W-1:0] len;
    if (b inside {[8'hF0:8'hF7]}) begin
      len = 3'd4;
    end else if (b inside {[8'hE0:8'hEF]}) begin
      len = 3'd3;
    end else if (b inside {[8'hC0:8'hDF]}) begin
      len = 3'd2;
    end else begin
      len = 3'd1;
    end
    return len;
  endfunction

  // Keeps the low bytes of a character, zero above
  function automatic logic [MAX_LEN*BYTE_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
    logic [MAX_LEN*BYTE_W-1:0] m;
    case (len)
      3'd1:    m = 32'h0000_00FF;
      3'd2:    m = 32'h0000_FFFF;
      3'd3:    m = 32'h00FF_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  // Counter value clamped to the output width
  function automatic logic [INDEX_OUT_W-1:0] clamp_index(input logic [INDEX_WIDTH-1:0] c);
    logic [INDEX_OUT_W-1:0] r;
    if (64'(c) > 64'(32'hFFFF)) begin
      r = 16'hFFFF;
    end else begin
      r = INDEX_OUT_W'(c);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/ucps_if.sv =====
`default_nettype none

// Byte input channel
interface ucps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_string;

  modport source (output valid, output byte_in, output end_of_string, input ready);
  modport sink   (input valid, input byte_in, input end_of_string, output ready);
endinterface

// Character output channel
interface ucps_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] char_value;
  logic [15:0] char_index;
  logic [2:0]  char_length;
  logic        last_char;

  modport source (output valid, output char_value, output char_index,
                  output char_length, output last_char, input ready);
  modport sink   (input valid, input char_value, input char_index,
                  input char_length, input last_char, output ready);
endinterface

`default_nettype wire

// ===== design/ucps_front.sv =====
`default_nettype none

module ucps_front (
  input  wire logic      clk,
  input  wire logic      rst,
  ucps_in_if.sink        in_ch,
  input  wire logic      q_full,
  output ucps_pkg::job_t push_job,
  output logic           push
);

  logic [2:0][7:0]                pending;
  logic [ucps_pkg::LEN_W-1:0]     exp_len;
  logic [1:0]                     held;

  ucps_pkg::char_buf_t            buf_w;
  logic [ucps_pkg::LEN_W-1:0]     n;
  logic [ucps_pkg::LEN_W-1:0]     e;
  logic                           accept;
  logic                           complete;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  // Append the new byte and decide whether a request is ready
  always_comb begin
    buf_w       = {8'h00, pending};
    buf_w[held] = in_ch.byte_in;
    n           = {1'b0, held} + 3'd1;
    e           = (exp_len != '0) ? exp_len : ucps_pkg::lead_length(in_ch.byte_in);
    complete    = (n >= e);

    push              = accept && (complete || in_ch.end_of_string);
    push_job.bytes    = buf_w;
    push_job.count    = n;
    push_job.reseg    = !complete;
    push_job.eos      = in_ch.end_of_string;
  end

  // Open sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      exp_len <= '0;
      held    <= '0;
    end else if (accept) begin
      if (complete || in_ch.end_of_string) begin
        pending <= '0;
        exp_len <= '0;
        held    <= '0;
      end else begin
        pending <= buf_w[2:0];
        exp_len <= e;
        held    <= n[1:0];
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/ucps_queue.sv =====
`default_nettype none

module ucps_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  ucps_pkg::job_t      push_job,
  output logic                full,
  input  wire logic           pop,
  output logic                q_valid,
  output ucps_pkg::job_t      q_job
);

  ucps_pkg::job_t mem [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_job   = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/ucps_back.sv =====
`default_nettype none

module ucps_back (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       q_valid,
  input  ucps_pkg::job_t  q_job,
  output logic            pop,
  ucps_out_if.source      out_ch
);

  ucps_pkg::job_t                    cur;
  logic                              cur_valid;
  logic [1:0]                        pos;
  logic [ucps_pkg::INDEX_WIDTH-1:0]  counter;

  logic                              out_valid;
  logic [31:0]                       out_value;
  logic [15:0]                       out_index;
  logic [2:0]                        out_length;
  logic                              out_last;

  logic                              advance;
  logic                              done;
  logic [ucps_pkg::LEN_W-1:0]        seg_len;
  logic [ucps_pkg::LEN_W-1:0]        len;
  logic [3:0]                        seg_end;
  logic [31:0]                       value;
  logic [ucps_pkg::INDEX_WIDTH-1:0]  counter_inc;

  assign out_ch.valid       = out_valid;
  assign out_ch.char_value  = out_value;
  assign out_ch.char_index  = out_index;
  assign out_ch.char_length = out_length;
  assign out_ch.last_char   = out_last;

  // Next character out of the current request
  always_comb begin
    seg_len = ucps_pkg::lead_length(cur.bytes[pos]);
    seg_end = {2'b00, pos} + {1'b0, seg_len};
    if (seg_end > {1'b0, cur.count}) begin
      seg_len = 3'd1;
      seg_end = {2'b00, pos} + 4'd1;
    end
    len  = cur.reseg ? seg_len : cur.count;
    done = !cur.reseg || (seg_end >= {1'b0, cur.count});
    value = (cur.bytes >> {pos, 3'b000}) & ucps_pkg::byte_mask(len);

    advance = cur_valid && (!out_valid || out_ch.ready);
    pop     = q_valid && (!cur_valid || (advance && done));

    counter_inc = (counter == '1) ? counter : counter + 1'b1;
  end

  // Current request and walk position
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      pos       <= '0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      pos       <= '0;
    end else if (advance) begin
      cur_valid <= !done;
      pos       <= seg_end[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_job;
    end
  end

  // Character counter, back to zero after the last character of a string
  always_ff @(posedge clk) begin
    if (rst) begin
      counter <= '0;
    end else if (advance) begin
      counter <= (done && cur.eos) ? '0 : counter_inc;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_value  <= value;
      out_index  <= ucps_pkg::clamp_index(counter);
      out_length <= len;
      out_last   <= done && cur.eos;
    end
  end

endmodule

`default_nettype wire

// ===== design/utf8_code_point_segmenter_unit.sv =====
// Channel  Dir  Payload                                           Accepted when
// in_ch    in   byte_in[7:0], end_of_string                       valid && ready
// out_ch   out  char_value[31:0], char_index[15:0],
//               char_length[2:0], last_char                       valid && ready
//
// One byte is taken per cycle while the queue is not full. A character
// passes through the queue entry, the current request register and then
// the back output register on its way to out_ch. A string that ends
// inside a sequence gives up to three characters from one byte; the back
// unit emits one per cycle unless out_ch stalls it, and the two-entry
// queue stalls the input only once it fills. Reset (rst, synchronous)
// empties the queue and clears the open sequence and the index counter.
`default_nettype none

module utf8_code_point_segmenter_unit (
  input  wire logic  clk,
  input  wire logic  rst,
  ucps_in_if.sink    in_ch,
  ucps_out_if.source out_ch
);

  ucps_pkg::job_t push_job;
  ucps_pkg::job_t q_job;
  logic           push;
  logic           q_full;
  logic           pop;
  logic           q_valid;

  ucps_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push_job (push_job),
    .push     (push)
  );

  ucps_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_job    (q_job)
  );

  ucps_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_job   (q_job),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

// ===== design/ucps_checker.sv =====
`default_nettype none

module ucps_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_value,
  input wire logic [15:0] out_index,
  input wire logic [2:0]  out_length,
  input wire logic        out_last
);

  logic        after_last;
  logic [15:0] prev_index;
  logic        out_fire;

  assign out_fire = out_valid && out_ready;

  // Track the previous delivered character
  always_ff @(posedge clk) begin
    if (rst) begin
      after_last <= 1'b1;
      prev_index <= '0;
    end else if (out_fire) begin
      after_last <= out_last;
      prev_index <= out_index;
    end
  end

  // A stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A new string starts at index zero
  a_first_index: assert property (@(posedge clk) disable iff (rst)
    out_fire && after_last |-> out_index == 16'h0000)
    else $error("string did not start at index zero");

  // Indexes inside a string step by one until saturation
  a_index_step: assert property (@(posedge clk) disable iff (rst)
    out_fire && !after_last |->
      (out_index == prev_index + 16'd1) || (prev_index == 16'hFFFF && out_index == 16'hFFFF))
    else $error("character index did not advance by one");

  // Length is 1..4 and bytes above the length are zero
  a_len_value: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_length >= 3'd1 && out_length <= 3'd4) &&
      (out_length != 3'd1 || out_value[31:8] == 24'h0) &&
      (out_length != 3'd2 || out_value[31:16] == 16'h0) &&
      (out_length != 3'd3 || out_value[31:24] == 8'h0))
    else $error("bad character length or stray high bytes");

endmodule

bind utf8_code_point_segmenter_unit ucps_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_value  (out_ch.char_value),
  .out_index  (out_ch.char_index),
  .out_length (out_ch.char_length),
  .out_last   (out_ch.last_char)
);

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int CYCLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 60;
  localparam int RANDOM_BYTES_PER_PHASE = 42;

  // One character as it leaves the block
  typedef struct packed {
    logic [31:0] value;
    logic [15:0] index;
    logic [2:0]  len;
    logic        last;
  } char_t;

  // One byte request, optionally with the character it must produce
  typedef struct packed {
    logic [7:0] b;
    logic       eos;
    logic       known;
    char_t      want;
  } byte_req_t;

  logic clk;
  logic rst;

  ucps_in_if  in_ch();
  ucps_out_if out_ch();

  utf8_code_point_segmenter_unit uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  byte_req_t byte_reqs[$];
  char_t     chars_due[$];
  char_t     step_chars[$];
  byte_req_t dir_tab[];

  int snd_idle_pct;
  int rcv_idle_pct;
  int hold_req;
  int errors;
  int cycles;
  int bytes_sent;
  int chars_seen;
  int strings_sent;

  // Segmenter state mirrored on the testbench side
  logic [2:0][7:0]                   pending;
  logic [2:0]                        open_len;
  logic [1:0]                        held_cnt;
  logic [ucps_pkg::INDEX_WIDTH-1:0]  char_cnt;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Sequence length announced by a lead byte
  function automatic int lead_len(input logic [7:0] b);
    int n;
    casez (b)
      8'b11110???: n = 4;
      8'b1110????: n = 3;
      8'b110?????: n = 2;
      default:     n = 1;
    endcase
    return n;
  endfunction

  // Pack one character and advance the saturating index
  task automatic emit_char(input logic [3:0][7:0] seq, input int start, input int len,
                           input logic last);
    char_t c;
    c.value = '0;
    for (int k = 0; k < len; k++) c.value[8*k +: 8] = seq[start+k];
    c.index = (64'(char_cnt) > 64'hFFFF) ? 16'hFFFF : 16'(char_cnt);
    c.len   = 3'(len);
    c.last  = last;
    step_chars.insert(step_chars.size(), c);
    if (char_cnt != '1) char_cnt++;
  endtask

  // Characters caused by one accepted byte, left in step_chars
  task automatic segment_byte(input logic [7:0] b, input logic eos);
    logic [3:0][7:0] seq;
    int n;
    int want;
    int i;
    int l;
    step_chars.delete();
    seq = {8'h00, pending[2], pending[1], pending[0]};
    seq[held_cnt] = b;
    n = int'(held_cnt) + 1;
    want = (open_len != 0) ? int'(open_len) : lead_len(b);
    if (n >= want) begin
      emit_char(seq, 0, n, eos);
      pending = '0; open_len = '0; held_cnt = '0;
    end else if (eos) begin
      // String ended inside a sequence: split the held bytes again
      i = 0;
      while (i < n) begin
        l = lead_len(seq[i]);
        if (i + l > n) l = 1;
        emit_char(seq, i, l, (i + l >= n));
        i += l;
      end
      pending = '0; open_len = '0; held_cnt = '0;
    end else begin
      pending  = {seq[2], seq[1], seq[0]};
      open_len = 3'(want);
      held_cnt = 2'(n);
    end
    if (eos) char_cnt = '0;
  endtask

  function automatic byte_req_t row(input logic [7:0] b, input logic eos);
    byte_req_t r;
    r = '0;
    r.b = b;
    r.eos = eos;
    return r;
  endfunction

  function automatic byte_req_t row_k(input logic [7:0] b, input logic eos,
                                      input logic [31:0] v, input logic [15:0] idx,
                                      input logic [2:0] len, input logic last);
    byte_req_t r;
    r = row(b, eos);
    r.known = 1'b1;
    r.want  = '{value: v, index: idx, len: len, last: last};
    return r;
  endfunction

  // Random string: mostly well-formed characters, some noise, sometimes cut short
  task automatic build_string(output int nbytes);
    logic [7:0] s[$];
    int nchars;
    int len;
    nchars = $urandom_range(1, 6);
    for (int c = 0; c < nchars; c++) begin
      if ($urandom_range(99) < 80) begin
        len = $urandom_range(1, 4);
        case (len)
          1: s.insert(s.size(), 8'($urandom_range(8'h00, 8'h7F)));
          2: s.insert(s.size(), 8'($urandom_range(8'hC0, 8'hDF)));
          3: s.insert(s.size(), 8'($urandom_range(8'hE0, 8'hEF)));
          default: s.insert(s.size(), 8'($urandom_range(8'hF0, 8'hF7)));
        endcase
        for (int k = 1; k < len; k++) s.insert(s.size(), 8'($urandom_range(8'h80, 8'hBF)));
      end else begin
        s.insert(s.size(), 8'($urandom_range(255)));
      end
    end
    if ($urandom_range(3) == 0) begin
      len = $urandom_range(2, 4);
      s.insert(s.size(), len == 2 ? 8'hC0 | 8'($urandom_range(31)) :
                         len == 3 ? 8'hE0 | 8'($urandom_range(15)) :
                                    8'hF0 | 8'($urandom_range(7)));
      for (int k = $urandom_range(0, len - 2); k > 0; k--)
        s.insert(s.size(), 8'($urandom_range(8'h80, 8'hBF)));
    end
    foreach (s[k]) byte_reqs.insert(byte_reqs.size(), row(s[k], k == s.size() - 1));
    nbytes = s.size();
    strings_sent++;
  endtask

  task automatic wait_drained();
    while (byte_reqs.size() != 0 || in_ch.valid || chars_due.size() != 0)
      @(negedge clk);
  endtask

  // Byte sender
  initial begin
    byte_req_t cur;
    in_ch.valid = 1'b0;
    in_ch.byte_in = '0;
    in_ch.end_of_string = 1'b0;
    cur = '0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (in_ch.valid && in_ch.ready) begin
          segment_byte(cur.b, cur.eos);
          if (cur.known) chars_due.insert(chars_due.size(), cur.want);
          else foreach (step_chars[k]) chars_due.insert(chars_due.size(), step_chars[k]);
          bytes_sent++;
        end
        if (!in_ch.valid || in_ch.ready) begin
          if (byte_reqs.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
            cur = byte_reqs.pop_front();
            in_ch.valid <= 1'b1;
            in_ch.byte_in <= cur.b;
            in_ch.end_of_string <= cur.eos;
          end else begin
            in_ch.valid <= 1'b0;
          end
        end
      end
    end
  end

  // Character receiver and checker
  initial begin
    char_t got;
    char_t want;
    int hold_cnt;
    int hold_seen;
    hold_cnt = 0;
    hold_seen = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) begin
        got = '{value: out_ch.char_value, index: out_ch.char_index,
                len: out_ch.char_length, last: out_ch.last_char};
        chars_seen++;
        if (chars_due.size() == 0) begin
          $display("%0t: unexpected character value %h index %0d length %0d last %0b",
                   $time, got.value, got.index, got.len, got.last);
          errors++;
        end else begin
          want = chars_due.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch: expected %h/%0d/%0d/%0b, got %h/%0d/%0d/%0b",
                     $time, want.value, want.index, want.len, want.last,
                     got.value, got.index, got.len, got.last);
            errors++;
          end
        end
      end
      // Long hold-off on request so the block backs up into its input
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int added;
    errors = 0; cycles = 0; bytes_sent = 0; chars_seen = 0; strings_sent = 0;
    hold_req = 0;
    snd_idle_pct = 17;
    rcv_idle_pct = 72;
    pending = '0; open_len = '0; held_cnt = '0; char_cnt = '0;
    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: extremes, each lead class, foreign followers, cut-off strings
    dir_tab = '{
      row_k(8'h00, 1'b1, 32'h0000_0000, 16'd0, 3'd1, 1'b1),
      row_k(8'hFF, 1'b1, 32'h0000_00FF, 16'd0, 3'd1, 1'b1),
      row_k(8'h41, 1'b0, 32'h0000_0041, 16'd0, 3'd1, 1'b0),
      row(8'hC3, 1'b0), row(8'hA9, 1'b0),
      row(8'hE2, 1'b0), row(8'h82, 1'b0), row(8'hAC, 1'b0),
      row(8'hF0, 1'b0), row(8'h9F, 1'b0), row(8'h98, 1'b0), row(8'h80, 1'b0),
      row(8'hC0, 1'b0), row(8'h41, 1'b0),
      row(8'hF8, 1'b0), row(8'h80, 1'b0),
      row(8'hF7, 1'b0), row(8'hE2, 1'b0), row(8'h82, 1'b1),
      row(8'hF0, 1'b0), row(8'hC3, 1'b0), row(8'hA9, 1'b1),
      row(8'hDF, 1'b1),
      row(8'hEF, 1'b0), row(8'hBF, 1'b1)
    };
    foreach (dir_tab[i]) byte_reqs.insert(byte_reqs.size(), dir_tab[i]);
    strings_sent += 6;
    wait_drained();

    // Random strings under three idling patterns
    for (int phase = 0; phase < 3; phase++) begin
      snd_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 72 : 0;
      rcv_idle_pct = (phase == 0) ? 72 : (phase == 1) ? 17 : 0;
      if (phase == 2) hold_req++;
      for (int n = 0; n < RANDOM_BYTES_PER_PHASE; n += added) build_string(added);
      wait_drained();
    end

    repeat (10) @(negedge clk);
    $display("Sent %0d bytes in %0d strings and checked %0d characters,", bytes_sent,
             strings_sent, chars_seen);
    $display("with truncated sequences, foreign followers, idle gaps and a long output stall.");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== utf8_code_point_segmenter_unit.f =====
design/ucps_pkg.sv
design/ucps_if.sv
design/ucps_front.sv
design/ucps_queue.sv
design/ucps_back.sv
design/utf8_code_point_segmenter_unit.sv
design/ucps_checker.sv
test/testbench.sv
